[rtl/azm_pkg.sv]
package azm_pkg;

    localparam int ANGLE_W        = 13;
    localparam int FREQ_W         = 16;
    localparam int SPEED_W        = 8;
    localparam int BAND_W         = 13;
    localparam int CFG_DATA_W     = 16;
    localparam int REG_IDX_W      = 3;
    localparam int IN_DATA_W      = 32;
    localparam int OUT_DATA_W     = 40;

    localparam int CIRCLE_DEFAULT = 6000;
    localparam int DIFF_MAX       = 8191;

    localparam int NUM_W          = 15;
    localparam int DIV_STEPS      = NUM_W;
    localparam int NUM_SLEW       = 11444;
    localparam int NUM_SCAN       = 17166;
    localparam int NUM_FINE       = 20000;
    localparam int TIER_SLEW      = 100;
    localparam int TIER_SCAN      = 66;
    localparam int TIER_TRACK     = 33;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLEW_SPEED  = 3'd0,
        REG_MID_SPEED   = 3'd1,
        REG_TRACK_SPEED = 3'd2,
        REG_BAND_UPPER  = 3'd3,
        REG_BAND_LOWER  = 3'd4,
        REG_IDLE_FREQ   = 3'd5,
        REG_IDLE_DIR    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0]       slew_speed;
        logic [SPEED_W-1:0]       mid_speed;
        logic [SPEED_W-1:0]       track_speed;
        logic signed [BAND_W-1:0] band_upper;
        logic signed [BAND_W-1:0] band_lower;
        logic [FREQ_W-1:0]        idle_freq;
        logic                     idle_dir;
    } cfg_t;

    // highest shift of the circle that still fits under the largest difference
    function automatic int mod_steps(input int circle);
        int k;
        k = 0;
        for (int i = 0; i < ANGLE_W; i++) begin
            if ((circle << (i + 1)) <= DIFF_MAX) begin
                k = i + 1;
            end
        end
        return k;
    endfunction

endpackage

[rtl/azm_sub_unit.sv]
module azm_sub_unit
    import azm_pkg::*;
#(
    parameter int WIDTH = ANGLE_W
) (
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    output logic [WIDTH-1:0] diff,
    output logic             ge
);

    logic [WIDTH:0] full;

    assign full = {1'b0, op_a} - {1'b0, op_b};
    assign diff = full[WIDTH-1:0];
    assign ge   = ~full[WIDTH];

endmodule

[rtl/azm_cfg_regs.sv]
module azm_cfg_regs
    import azm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SLEW_SPEED:  cfg_next.slew_speed  = cfg_data[SPEED_W-1:0];
                REG_MID_SPEED:   cfg_next.mid_speed   = cfg_data[SPEED_W-1:0];
                REG_TRACK_SPEED: cfg_next.track_speed = cfg_data[SPEED_W-1:0];
                REG_BAND_UPPER:  cfg_next.band_upper  = cfg_data[BAND_W-1:0];
                REG_BAND_LOWER:  cfg_next.band_lower  = cfg_data[BAND_W-1:0];
                REG_IDLE_FREQ:   cfg_next.idle_freq   = cfg_data[FREQ_W-1:0];
                REG_IDLE_DIR:    cfg_next.idle_dir    = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slew_speed  <= SPEED_W'(1);
            cfg_reg.mid_speed   <= SPEED_W'(1);
            cfg_reg.track_speed <= SPEED_W'(1);
            cfg_reg.band_upper  <= BAND_W'(2);
            cfg_reg.band_lower  <= -BAND_W'(2);
            cfg_reg.idle_freq   <= '0;
            cfg_reg.idle_dir    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/azimuth_track_motor_step.sv]
// azimuth tracking motor step, one word in and one word out per control tick
// s_ channel: tick word with enable, measured and target angle, elevation
//   ready and the scan / azimuth start requests
// m_ channel: step frequency, direction, motor enable, wrapped error and the
//   tracking flags after the tick
// cfg_ port: register writes, taken at any edge with cfg_wr_en high
// an enabled word reduces the angle difference on the shared subtractor
//   (one step per power-of-two multiple of the circle, one step for 6000
//   counts), then runs a 15-step restoring division of the tier constant by
//   the configured speed on the same subtractor
// a disabled word skips the reduction and the division and goes straight to
//   the output state with the idle frequency and direction and the motor off
// s_tready is high only while no word is in work, so a new word is accepted
//   only after the previous one has been loaded into the result register
// the result register lets the next word in while a result waits; a word
//   that finishes before its predecessor is taken waits in place
// reset clears the flags and m_tvalid and puts the config registers to their defaults
module azimuth_track_motor_step
    import azm_pkg::*;
#(
    parameter int CIRCLE_COUNTS = CIRCLE_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // track_enable, measured_angle, target_angle, elev_ready,
    // scan_start_set, phi_start_set, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // step_freq, motor_dir, motor_on, wrapped_error, error_moving,
    // phi_active, elev_start, track_done, scan_pending, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CIRC_W   = $clog2(CIRCLE_COUNTS + 1);
    localparam int SUB_W    = (CIRC_W > ANGLE_W) ? CIRC_W : ANGLE_W;
    localparam int ERR_W    = SUB_W + 1;
    localparam int HALF     = CIRCLE_COUNTS / 2;
    localparam int MOD_HI   = mod_steps(CIRCLE_COUNTS);
    localparam int STEP_MAX = (MOD_HI > DIV_STEPS - 1) ? MOD_HI : DIV_STEPS - 1;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MOD    = 6'b000010,
        ST_WRAP   = 6'b000100,
        ST_SELECT = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    cfg_t cfg;

    azm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg;
    logic [SUB_W-1:0]          rem_reg;
    logic                      neg_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          quot_reg;
    logic [SPEED_W-1:0]        den_reg;
    logic [FREQ_W-1:0]         freq_reg;
    logic                      dir_reg;
    logic                      on_reg;
    logic                      elev_ready_reg;
    logic                      scan_flag_reg;
    logic                      phi_flag_reg;
    logic                      elev_flag_reg;
    logic                      done_flag_reg;
    logic                      moving_flag_reg;
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;

    logic                      in_en;
    logic [ANGLE_W-1:0]        in_measured;
    logic [ANGLE_W-1:0]        in_target;
    logic                      accept;
    logic                      out_load;
    logic signed [ANGLE_W:0]   diff_in;
    logic [ANGLE_W-1:0]        diff_abs;

    logic [SUB_W-1:0]          sub_a, sub_b, sub_diff;
    logic                      sub_ge;
    logic [SUB_W-1:0]          circle_shift;
    logic [SUB_W-1:0]          div_trial;

    logic [SUB_W-1:0]          wrap_r;
    logic signed [ERR_W-1:0]   wrap_err;
    logic [ERR_W-1:0]          err_mag;
    logic signed [ERR_W-1:0]   band_hi, band_lo;
    logic [NUM_W-1:0]          num_sel;
    logic [SPEED_W-1:0]        den_sel;
    logic [NUM_W-1:0]          quot_next;

    assign in_en       = s_tdata[0];
    assign in_measured = s_tdata[ANGLE_W:1];
    assign in_target   = s_tdata[2*ANGLE_W:ANGLE_W+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign diff_in  = $signed({1'b0, in_measured}) - $signed({1'b0, in_target});
    assign diff_abs = diff_in[ANGLE_W] ? ANGLE_W'(-diff_in) : diff_in[ANGLE_W-1:0];

    // shared subtractor: circle reduction, then quotient bits
    assign circle_shift = SUB_W'(CIRCLE_COUNTS) << step_reg;
    assign div_trial    = {(SUB_W-SPEED_W-1)'(0), rem_reg[SPEED_W-1:0], num_reg[NUM_W-1]};

    always_comb begin
        sub_a = rem_reg;
        sub_b = circle_shift;
        if (state_reg == ST_DIV) begin
            sub_a = div_trial;
            sub_b = SUB_W'(den_reg);
        end
    end

    azm_sub_unit #(
        .WIDTH (SUB_W)
    ) u_sub (
        .op_a (sub_a),
        .op_b (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    assign wrap_r = (neg_reg && (rem_reg != '0)) ? SUB_W'(CIRCLE_COUNTS) - rem_reg : rem_reg;

    always_comb begin
        if (wrap_r >= SUB_W'(HALF)) begin
            wrap_err = $signed({1'b0, wrap_r}) - $signed(ERR_W'(CIRCLE_COUNTS));
        end else begin
            wrap_err = $signed({1'b0, wrap_r});
        end
    end

    assign err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign band_hi = ERR_W'(cfg.band_upper);
    assign band_lo = ERR_W'(cfg.band_lower);

    always_comb begin
        if (err_mag >= ERR_W'(TIER_SLEW)) begin
            num_sel = NUM_W'(NUM_SLEW);
            den_sel = cfg.slew_speed;
        end else if (err_mag >= ERR_W'(TIER_SCAN)) begin
            num_sel = NUM_W'(NUM_SCAN);
            den_sel = cfg.mid_speed;
        end else if (err_mag >= ERR_W'(TIER_TRACK)) begin
            num_sel = NUM_W'(NUM_SCAN);
            den_sel = cfg.track_speed;
        end else begin
            num_sel = NUM_W'(NUM_FINE);
            den_sel = cfg.track_speed;
        end
    end

    assign quot_next = {quot_reg[NUM_W-2:0], sub_ge};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = in_en ? ST_MOD : ST_OUT;
            ST_MOD:    if (step_reg == '0) state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_SELECT;
            ST_SELECT: state_next = ST_DIV;
            ST_DIV:    if (step_reg == '0) state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            scan_flag_reg   <= 1'b0;
            phi_flag_reg    <= 1'b0;
            elev_flag_reg   <= 1'b0;
            done_flag_reg   <= 1'b0;
            moving_flag_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (s_tdata[2*ANGLE_W+2]) scan_flag_reg <= 1'b1;
                if (s_tdata[2*ANGLE_W+3]) phi_flag_reg  <= 1'b1;
            end
            if (state_reg == ST_SELECT) begin
                if (err_reg >= band_hi || err_reg <= band_lo) begin
                    moving_flag_reg <= 1'b1;
                end else begin
                    moving_flag_reg <= 1'b0;
                    phi_flag_reg    <= 1'b0;
                    if (scan_flag_reg) begin
                        elev_flag_reg <= 1'b0;
                        done_flag_reg <= 1'b1;
                        scan_flag_reg <= 1'b0;
                    end else if (elev_ready_reg) begin
                        elev_flag_reg <= 1'b1;
                        done_flag_reg <= 1'b0;
                    end else begin
                        elev_flag_reg <= 1'b0;
                        done_flag_reg <= 1'b1;
                    end
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    elev_ready_reg <= s_tdata[2*ANGLE_W+1];
                    rem_reg        <= SUB_W'(diff_abs);
                    neg_reg        <= diff_in[ANGLE_W];
                    step_reg       <= STEP_W'(MOD_HI);
                    freq_reg       <= cfg.idle_freq;
                    dir_reg        <= cfg.idle_dir;
                    on_reg         <= 1'b0;
                    err_reg        <= '0;
                end
            end
            ST_MOD: begin
                if (sub_ge) rem_reg <= sub_diff;
                if (step_reg != '0) step_reg <= step_reg - STEP_W'(1);
            end
            ST_WRAP: begin
                err_reg <= wrap_err;
            end
            ST_SELECT: begin
                num_reg  <= num_sel;
                den_reg  <= den_sel;
                quot_reg <= '0;
                rem_reg  <= '0;
                step_reg <= STEP_W'(DIV_STEPS - 1);
                if (err_reg >= band_hi) begin
                    dir_reg <= 1'b0;
                    on_reg  <= 1'b1;
                end else if (err_reg <= band_lo) begin
                    dir_reg <= 1'b1;
                    on_reg  <= 1'b1;
                end else begin
                    dir_reg <= 1'b1;
                    on_reg  <= 1'b0;
                end
            end
            ST_DIV: begin
                rem_reg  <= sub_ge ? sub_diff : div_trial;
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                quot_reg <= quot_next;
                if (step_reg != '0) begin
                    step_reg <= step_reg - STEP_W'(1);
                end else begin
                    freq_reg <= (den_reg == '0) ? '1 : FREQ_W'(quot_next);
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= {
                        (OUT_DATA_W-FREQ_W-ANGLE_W-7)'(0),
                        scan_flag_reg, done_flag_reg, elev_flag_reg, phi_flag_reg,
                        moving_flag_reg, err_reg[ANGLE_W-1:0], on_reg, dir_reg, freq_reg
                    };
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_no_accept_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("word accepted while previous word still in work");

    a_elev_done_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(elev_flag_reg && done_flag_reg))
        else $error("elevation start and done flags both set");

    a_on_implies_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[FREQ_W+1]) |-> m_tdata_reg[FREQ_W+ANGLE_W+2])
        else $error("motor enabled without moving flag");
`endif

endmodule
